// ----- sv/mlfq_pkg.sv -----
// ----------------------------------------------------------------------------
// Feedback queue scheduler package
// Shared constants, codes and the command and status structures that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_PROCS_DEF  = 16;
  localparam int MAX_BURSTS_DEF = 16;

  localparam int TIME_W     = 12;
  localparam int CNT_W      = 24;
  localparam int QUANT_W    = 8;
  localparam int PCNT_W     = 5;
  localparam int PIDX_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [QUANT_W-1:0] Q1_RESET     = 8'd7;
  localparam logic [QUANT_W-1:0] Q2_RESET     = 8'd14;
  localparam logic [PCNT_W-1:0]  PCOUNT_RESET = 5'd9;
  localparam logic [CNT_W-1:0]   CNT_MAX      = 24'hFFFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PCOUNT   = 2'd2;

  // Input operation codes.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_RUN    = 1'b1;

  typedef enum logic [1:0] {
    QUEUE_TOP,
    QUEUE_MID,
    QUEUE_LOW
  } queue_t;

  typedef enum logic [1:0] {
    MODE_L1,
    MODE_L2,
    MODE_L3,
    MODE_IDLE
  } mode_t;

  typedef struct packed {
    logic   clear_run;
    logic   load_wr;
    logic   idx_clr;
    logic   idx_inc;
    logic   init_push;
    logic   pop;
    queue_t pop_q;
    logic   dispatch;
    logic   load_rb;
    logic   tick;
    logic   io_pop;
    logic   preempt;
    logic   end_slice;
    mode_t  mode;
  } ctrl_cmd_t;

  typedef struct packed {
    logic top_ne;
    logic mid_ne;
    logic low_ne;
    logic io_ne;
    logic io_head_zero;
    logic rb_nz;
    logic t_lt_q;
    logic idx_last;
    logic n_zero;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic queue_t queue_of(input mode_t m);
    queue_t q;
    case (m)
      MODE_L1: q = QUEUE_TOP;
      MODE_L2: q = QUEUE_MID;
      default: q = QUEUE_LOW;
    endcase
    return q;
  endfunction

endpackage

// ----- sv/mlfq_in_if.sv -----
// ----------------------------------------------------------------------------
// Scheduler input channel
// Valid/ready channel carrying load and run transactions.
// ----------------------------------------------------------------------------
interface mlfq_in_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [mlfq_pkg::PIDX_W-1:0]    process_index;
  logic [mlfq_pkg::TIME_W-1:0]    cpu_burst;
  logic [mlfq_pkg::TIME_W-1:0]    io_time;

  modport source (output valid, operation, process_index, cpu_burst, io_time,
                  input ready);
  modport sink (input valid, operation, process_index, cpu_burst, io_time,
                output ready);
endinterface

// ----- sv/mlfq_out_if.sv -----
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying one per-process report per transaction.
// ----------------------------------------------------------------------------
interface mlfq_out_if;
  logic                          valid;
  logic                          ready;
  logic [mlfq_pkg::PCNT_W-1:0]   process_id;
  logic [mlfq_pkg::CNT_W-1:0]    response_time;
  logic [mlfq_pkg::CNT_W-1:0]    wait_time;
  logic [mlfq_pkg::CNT_W-1:0]    finish_time;
  logic [mlfq_pkg::CNT_W-1:0]    total_clock;
  logic [mlfq_pkg::CNT_W-1:0]    idle_ticks;
  logic                          last;

  modport source (output valid, process_id, response_time, wait_time, finish_time,
                  total_clock, idle_ticks, last, input ready);
  modport sink (input valid, process_id, response_time, wait_time, finish_time,
                total_clock, idle_ticks, last, output ready);
endinterface

// ----- sv/mlfq_fifo.sv -----
// ----------------------------------------------------------------------------
// Ready queue
// Circular buffer of process indexes with a synchronous clear.
// ----------------------------------------------------------------------------
module mlfq_fifo #(
  parameter int DEPTH = mlfq_pkg::MAX_PROCS_DEF,
  parameter int W     = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         clr,
  input  logic         push,
  input  logic [W-1:0] push_id,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         not_empty
);
  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    entry_r [DEPTH];
  logic [PTRW-1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTRW-1:0] wrap_inc(input logic [PTRW-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_nxt  = rd_r;
    wr_nxt  = wr_r;
    cnt_nxt = cnt_r;
    if (clr) begin
      rd_nxt  = '0;
      wr_nxt  = '0;
      cnt_nxt = '0;
    end else begin
      if (push) begin
        wr_nxt = wrap_inc(wr_r);
      end
      if (pop) begin
        rd_nxt = wrap_inc(rd_r);
      end
      if (push && !pop) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !clr) begin
      entry_r[wr_r] <= push_id;
    end
  end

  assign head      = entry_r[rd_r];
  assign not_empty = (cnt_r != '0);
endmodule

// ----- sv/mlfq_dp.sv -----
// ----------------------------------------------------------------------------
// Scheduler datapath
// Burst store, per-process state, ready queues, the ordered I/O list and the
// tick counters, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module mlfq_dp #(
  parameter int MAX_PROCS  = mlfq_pkg::MAX_PROCS_DEF,
  parameter int MAX_BURSTS = mlfq_pkg::MAX_BURSTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mlfq_pkg::ctrl_cmd_t                 cmd,
  output mlfq_pkg::dp_status_t                status,
  input  logic                                cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [mlfq_pkg::PIDX_W-1:0]         ld_process_index,
  input  logic [mlfq_pkg::TIME_W-1:0]         ld_cpu_burst,
  input  logic [mlfq_pkg::TIME_W-1:0]         ld_io_time,
  output logic [mlfq_pkg::PCNT_W-1:0]         rpt_process_id,
  output logic [mlfq_pkg::CNT_W-1:0]          rpt_response_time,
  output logic [mlfq_pkg::CNT_W-1:0]          rpt_wait_time,
  output logic [mlfq_pkg::CNT_W-1:0]          rpt_finish_time,
  output logic [mlfq_pkg::CNT_W-1:0]          rpt_total_clock,
  output logic [mlfq_pkg::CNT_W-1:0]          rpt_idle_ticks
);
  localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int NW    = $clog2(MAX_PROCS + 1);
  localparam int LW    = $clog2(MAX_BURSTS + 1);
  localparam int DEPTH = MAX_PROCS * MAX_BURSTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = mlfq_pkg::TIME_W;
  localparam int CW    = mlfq_pkg::CNT_W;
  localparam int QW    = mlfq_pkg::QUANT_W;

  // Configuration registers.
  logic [QW-1:0]                   q1_r, q2_r;
  logic [mlfq_pkg::PCNT_W-1:0]     pcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r     <= mlfq_pkg::Q1_RESET;
      q2_r     <= mlfq_pkg::Q2_RESET;
      pcount_r <= mlfq_pkg::PCOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfq_pkg::CFG_QUANTUM1: q1_r <= cfg_data;
        mlfq_pkg::CFG_QUANTUM2: q2_r <= cfg_data;
        mlfq_pkg::CFG_PCOUNT:   pcount_r <= cfg_data[mlfq_pkg::PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_procs;
  assign n_procs = (int'(pcount_r) > MAX_PROCS) ? NW'(MAX_PROCS) : NW'(pcount_r);

  // State
  logic [LW-1:0] len_r  [MAX_PROCS];
  logic [LW-1:0] pos_r  [MAX_PROCS];
  logic [TW-1:0] rb_r   [MAX_PROCS];
  logic [TW-1:0] rio_r  [MAX_PROCS];
  logic [CW-1:0] wait_r [MAX_PROCS];
  logic [CW-1:0] resp_r [MAX_PROCS];
  logic [CW-1:0] fin_r  [MAX_PROCS];
  logic [MAX_PROCS-1:0] nr_r, inrq_r;
  logic [PW-1:0] runner_r;
  logic [NW-1:0] idx_r;
  logic [QW-1:0] t_r;
  logic [CW-1:0] clock_r, idle_r;
  logic          load_pend_r;

  // I/O list: a row of cells kept sorted by remaining time.
  logic                    cv_r [MAX_PROCS];
  logic [PW-1:0]           cid_r [MAX_PROCS];
  logic [TW-1:0]           ck_r [MAX_PROCS];
  mlfq_pkg::queue_t        cl_r [MAX_PROCS];
  logic                    cv_nxt [MAX_PROCS];
  logic [PW-1:0]           cid_nxt [MAX_PROCS];
  logic [TW-1:0]           ck_nxt [MAX_PROCS];
  mlfq_pkg::queue_t        cl_nxt [MAX_PROCS];
  logic [MAX_PROCS-1:0]    le;

  logic [6:0]    p_ext;
  logic          p_ok;
  logic [PW-1:0] p_idx, idx_pw, len_addr;
  logic [LW-1:0] len_sel, pos_run, len_run;
  logic [TW-1:0] rb_run;
  logic          can_append, need_load, io_insert;

  assign p_ext  = {3'b000, ld_process_index};
  assign p_ok   = int'(p_ext) < MAX_PROCS;
  assign p_idx  = p_ext[PW-1:0];
  assign idx_pw = idx_r[PW-1:0];

  always_comb begin
    if (cmd.load_wr) begin
      len_addr = p_idx;
    end else if (cmd.init_push) begin
      len_addr = idx_pw;
    end else begin
      len_addr = runner_r;
    end
  end

  assign len_sel    = len_r[len_addr];
  assign len_run    = len_sel;
  assign pos_run    = pos_r[runner_r];
  assign rb_run     = rb_r[runner_r];
  assign can_append = cmd.load_wr && p_ok && (int'(len_sel) < MAX_BURSTS);
  assign need_load  = (rb_run == '0) && (pos_run < len_run);
  assign io_insert  = cmd.end_slice && (rb_run == '0) && (pos_run < len_run);

  // Burst store: burst in the upper half, I/O time in the lower half.
  logic [2*TW-1:0] mem [DEPTH];
  logic [2*TW-1:0] mem_q;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [TW-1:0]   wb, wio;

  assign wr_addr = AW'(p_idx) * AW'(MAX_BURSTS) + AW'(len_sel);
  assign rd_addr = AW'(runner_r) * AW'(MAX_BURSTS) + AW'(pos_run);
  assign wb      = (ld_cpu_burst == '0) ? TW'(1) : ld_cpu_burst;
  assign wio     = (ld_io_time == '0) ? TW'(1) : ld_io_time;

  always_ff @(posedge clk) begin
    if (can_append) begin
      mem[wr_addr] <= {wb, wio};
    end
    mem_q <= mem[rd_addr];
  end

  // Ready queues share one push port.
  logic             push_en;
  mlfq_pkg::queue_t push_q;
  logic [PW-1:0]    push_id;
  logic [PW-1:0]    head_top, head_mid, head_low, head_sel;
  logic             ne_top, ne_mid, ne_low;

  always_comb begin
    push_en = 1'b0;
    push_q  = mlfq_pkg::QUEUE_TOP;
    push_id = runner_r;
    if (cmd.init_push && (len_sel != '0)) begin
      push_en = 1'b1;
      push_id = idx_pw;
    end else if (cmd.io_pop) begin
      push_en = 1'b1;
      push_q  = cl_r[0];
      push_id = cid_r[0];
    end else if (cmd.preempt) begin
      push_en = 1'b1;
      push_q  = mlfq_pkg::queue_of(cmd.mode);
    end else if (cmd.end_slice && (rb_run != '0)) begin
      push_en = 1'b1;
      push_q  = (cmd.mode == mlfq_pkg::MODE_L1) ? mlfq_pkg::QUEUE_MID
                                               : mlfq_pkg::QUEUE_LOW;
    end
  end

  mlfq_fifo #(.DEPTH(MAX_PROCS), .W(PW)) u_top (
    .clk, .rst_n, .clr(cmd.clear_run),
    .push(push_en && (push_q == mlfq_pkg::QUEUE_TOP)), .push_id,
    .pop(cmd.pop && (cmd.pop_q == mlfq_pkg::QUEUE_TOP)),
    .head(head_top), .not_empty(ne_top)
  );
  mlfq_fifo #(.DEPTH(MAX_PROCS), .W(PW)) u_mid (
    .clk, .rst_n, .clr(cmd.clear_run),
    .push(push_en && (push_q == mlfq_pkg::QUEUE_MID)), .push_id,
    .pop(cmd.pop && (cmd.pop_q == mlfq_pkg::QUEUE_MID)),
    .head(head_mid), .not_empty(ne_mid)
  );
  mlfq_fifo #(.DEPTH(MAX_PROCS), .W(PW)) u_low (
    .clk, .rst_n, .clr(cmd.clear_run),
    .push(push_en && (push_q == mlfq_pkg::QUEUE_LOW)), .push_id,
    .pop(cmd.pop && (cmd.pop_q == mlfq_pkg::QUEUE_LOW)),
    .head(head_low), .not_empty(ne_low)
  );

  always_comb begin
    case (cmd.pop_q)
      mlfq_pkg::QUEUE_TOP: head_sel = head_top;
      mlfq_pkg::QUEUE_MID: head_sel = head_mid;
      default:             head_sel = head_low;
    endcase
  end

  // I/O list next state: clear, parallel insert, shift out of the head, or count down.
  always_comb begin
    for (int k = 0; k < MAX_PROCS; k++) begin
      le[k] = cv_r[k] && (ck_r[k] <= rio_r[runner_r]);
    end
    for (int k = 0; k < MAX_PROCS; k++) begin
      cv_nxt[k]  = cv_r[k];
      cid_nxt[k] = cid_r[k];
      ck_nxt[k]  = ck_r[k];
      cl_nxt[k]  = cl_r[k];
      if (cmd.clear_run) begin
        cv_nxt[k] = 1'b0;
      end else if (io_insert) begin
        if (!le[k]) begin
          if (k == 0 || le[(k == 0) ? 0 : k - 1]) begin
            cv_nxt[k]  = 1'b1;
            cid_nxt[k] = runner_r;
            ck_nxt[k]  = rio_r[runner_r];
            cl_nxt[k]  = mlfq_pkg::queue_of(cmd.mode);
          end else begin
            cv_nxt[k]  = cv_r[(k == 0) ? 0 : k - 1];
            cid_nxt[k] = cid_r[(k == 0) ? 0 : k - 1];
            ck_nxt[k]  = ck_r[(k == 0) ? 0 : k - 1];
            cl_nxt[k]  = cl_r[(k == 0) ? 0 : k - 1];
          end
        end
      end else if (cmd.io_pop) begin
        if (k == MAX_PROCS - 1) begin
          cv_nxt[k] = 1'b0;
        end else begin
          cv_nxt[k]  = cv_r[(k == MAX_PROCS - 1) ? k : k + 1];
          cid_nxt[k] = cid_r[(k == MAX_PROCS - 1) ? k : k + 1];
          ck_nxt[k]  = ck_r[(k == MAX_PROCS - 1) ? k : k + 1];
          cl_nxt[k]  = cl_r[(k == MAX_PROCS - 1) ? k : k + 1];
        end
      end else if (cmd.tick) begin
        if (cv_r[k] && (ck_r[k] != '0)) begin
          ck_nxt[k] = ck_r[k] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PROCS; k++) begin
      cid_r[k] <= cid_nxt[k];
      ck_r[k]  <= ck_nxt[k];
      cl_r[k]  <= cl_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PROCS; k++) begin
        cv_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < MAX_PROCS; k++) begin
        cv_r[k] <= cv_nxt[k];
      end
    end
  end

  // Per-process state and run counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        len_r[i]  <= '0;
        pos_r[i]  <= '0;
        rb_r[i]   <= '0;
        rio_r[i]  <= '0;
        wait_r[i] <= '0;
        resp_r[i] <= '0;
        fin_r[i]  <= '0;
      end
      nr_r        <= '1;
      inrq_r      <= '0;
      runner_r    <= '0;
      idx_r       <= '0;
      t_r         <= '0;
      clock_r     <= '0;
      idle_r      <= '0;
      load_pend_r <= 1'b0;
    end else begin
      if (can_append) begin
        len_r[p_idx] <= len_sel + 1'b1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end

      if (cmd.clear_run) begin
        for (int i = 0; i < MAX_PROCS; i++) begin
          pos_r[i]  <= '0;
          rb_r[i]   <= '0;
          rio_r[i]  <= '0;
          wait_r[i] <= '0;
          resp_r[i] <= '0;
          fin_r[i]  <= '0;
        end
        nr_r    <= '1;
        inrq_r  <= '0;
        clock_r <= '0;
        idle_r  <= '0;
      end else begin
        if (cmd.pop) begin
          runner_r          <= head_sel;
          inrq_r[head_sel]  <= 1'b0;
        end
        if (push_en) begin
          inrq_r[push_id] <= 1'b1;
        end
        if (cmd.dispatch) begin
          load_pend_r <= need_load;
          t_r         <= '0;
          if (need_load) begin
            pos_r[runner_r] <= pos_run + 1'b1;
          end
          if (nr_r[runner_r]) begin
            nr_r[runner_r]   <= 1'b0;
            resp_r[runner_r] <= clock_r;
          end
        end
        if (cmd.load_rb && load_pend_r) begin
          rb_r[runner_r]  <= mem_q[2*TW-1:TW];
          rio_r[runner_r] <= mem_q[TW-1:0];
        end
        if (cmd.tick) begin
          clock_r <= mlfq_pkg::sat_inc(clock_r);
          if (cmd.mode == mlfq_pkg::MODE_IDLE) begin
            idle_r <= mlfq_pkg::sat_inc(idle_r);
          end else begin
            rb_r[runner_r] <= rb_run - 1'b1;
            t_r            <= t_r + 1'b1;
          end
          // Only processes waiting before this tick's I/O returns count.
          for (int i = 0; i < MAX_PROCS; i++) begin
            if (inrq_r[i]) begin
              wait_r[i] <= mlfq_pkg::sat_inc(wait_r[i]);
            end
          end
        end
        if (cmd.end_slice && (rb_run == '0) && !(pos_run < len_run)) begin
          fin_r[runner_r] <= clock_r;
        end
      end
    end
  end

  always_comb begin
    status.top_ne       = ne_top;
    status.mid_ne       = ne_mid;
    status.low_ne       = ne_low;
    status.io_ne        = cv_r[0];
    status.io_head_zero = cv_r[0] && (ck_r[0] == '0);
    status.rb_nz        = (rb_run != '0);
    case (cmd.mode)
      mlfq_pkg::MODE_L1: status.t_lt_q = (t_r < q1_r);
      mlfq_pkg::MODE_L2: status.t_lt_q = (t_r < q2_r);
      default:           status.t_lt_q = 1'b0;
    endcase
    status.idx_last = (NW'(idx_r + 1'b1) == n_procs);
    status.n_zero   = (n_procs == '0);
  end

  assign rpt_process_id    = mlfq_pkg::PCNT_W'(32'(idx_r) + 32'd1);
  assign rpt_response_time = resp_r[idx_pw];
  assign rpt_wait_time     = wait_r[idx_pw];
  assign rpt_finish_time   = fin_r[idx_pw];
  assign rpt_total_clock   = clock_r;
  assign rpt_idle_ticks    = idle_r;
endmodule

// ----- sv/mlfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences loading, run setup, dispatch, ticks, I/O returns and reporting.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_operation,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  mlfq_pkg::dp_status_t  status,
  output mlfq_pkg::ctrl_cmd_t   cmd
);
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_INIT,
    S_SCHED,
    S_DISP,
    S_LOAD,
    S_CHECK,
    S_TICK,
    S_RELEASE,
    S_END,
    S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  mlfq_pkg::mode_t mode_r, mode_nxt;
  logic            after_tick_r, after_tick_nxt;
  logic            cont, any_ready;

  assign any_ready = status.top_ne || status.mid_ne || status.low_ne;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    after_tick_nxt = after_tick_r;
    cmd            = '0;
    cmd.mode       = mode_r;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cont           = (mode_r == mlfq_pkg::MODE_L3) ? status.rb_nz
                                                   : (status.t_lt_q && status.rb_nz);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == mlfq_pkg::OP_RUN) begin
            state_nxt = S_CLEAR;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear_run = 1'b1;
        cmd.idx_clr   = 1'b1;
        state_nxt     = S_INIT;
      end
      S_INIT: begin
        if (status.n_zero) begin
          state_nxt = S_SCHED;
        end else begin
          cmd.init_push = 1'b1;
          if (status.idx_last) begin
            state_nxt = S_SCHED;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_SCHED: begin
        if (status.top_ne) begin
          cmd.pop   = 1'b1;
          cmd.pop_q = mlfq_pkg::QUEUE_TOP;
          mode_nxt  = mlfq_pkg::MODE_L1;
          state_nxt = S_DISP;
        end else if (status.mid_ne) begin
          cmd.pop   = 1'b1;
          cmd.pop_q = mlfq_pkg::QUEUE_MID;
          mode_nxt  = mlfq_pkg::MODE_L2;
          state_nxt = S_DISP;
        end else if (status.low_ne) begin
          cmd.pop   = 1'b1;
          cmd.pop_q = mlfq_pkg::QUEUE_LOW;
          mode_nxt  = mlfq_pkg::MODE_L3;
          state_nxt = S_DISP;
        end else if (status.io_ne) begin
          mode_nxt  = mlfq_pkg::MODE_IDLE;
          state_nxt = S_TICK;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = status.n_zero ? S_IDLE : S_OUT;
        end
      end
      S_DISP: begin
        cmd.dispatch   = 1'b1;
        after_tick_nxt = 1'b0;
        state_nxt      = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_rb = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (mode_r == mlfq_pkg::MODE_IDLE) begin
          state_nxt = (any_ready || !status.io_ne) ? S_SCHED : S_TICK;
        end else if (after_tick_r && status.rb_nz &&
                     (((mode_r == mlfq_pkg::MODE_L2) && status.top_ne) ||
                      ((mode_r == mlfq_pkg::MODE_L3) &&
                       (status.top_ne || status.mid_ne)))) begin
          // A higher level became ready: the runner goes back to its own queue.
          cmd.preempt = 1'b1;
          state_nxt   = S_SCHED;
        end else if (cont) begin
          state_nxt = S_TICK;
        end else begin
          state_nxt = S_END;
        end
      end
      S_TICK: begin
        cmd.tick       = 1'b1;
        after_tick_nxt = 1'b1;
        state_nxt      = S_RELEASE;
      end
      S_RELEASE: begin
        if (status.io_head_zero) begin
          cmd.io_pop = 1'b1;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_END: begin
        cmd.end_slice = 1'b1;
        state_nxt     = S_SCHED;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= mlfq_pkg::MODE_L1;
      after_tick_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      after_tick_r <= after_tick_nxt;
    end
  end
endmodule

// ----- sv/multilevel_feedback_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// Three-level feedback queue scheduler
// Loads per-process burst lists and simulates feedback queue scheduling.
// ----------------------------------------------------------------------------
// A load transaction is taken while idle. A run transaction occupies the block
// until its last report is taken: it clears the run state and fills the top
// queue one process at a time, then dispatches (schedule, dispatch, load, check),
// ticks (tick, release, check), returns processes from I/O one at a time, ends
// slices, finds the queues empty and sends the reports as the sink takes them. The tick
// sequencer handles one simulated tick at a time, and the burst store has a
// single registered read port.
// Reports come out in ascending process order with the last one flagged.
module multilevel_feedback_queue_scheduler #(
  parameter int MAX_PROCS  = mlfq_pkg::MAX_PROCS_DEF,
  parameter int MAX_BURSTS = mlfq_pkg::MAX_BURSTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mlfq_in_if.sink                          in_chan,
  mlfq_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  mlfq_pkg::ctrl_cmd_t  cmd;
  mlfq_pkg::dp_status_t status;

  mlfq_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_chan.ready),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .status,
    .cmd
  );

  mlfq_dp #(.MAX_PROCS(MAX_PROCS), .MAX_BURSTS(MAX_BURSTS)) u_dp (
    .clk,
    .rst_n,
    .cmd,
    .status,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .ld_process_index  (in_chan.process_index),
    .ld_cpu_burst      (in_chan.cpu_burst),
    .ld_io_time        (in_chan.io_time),
    .rpt_process_id    (out_chan.process_id),
    .rpt_response_time (out_chan.response_time),
    .rpt_wait_time     (out_chan.wait_time),
    .rpt_finish_time   (out_chan.finish_time),
    .rpt_total_clock   (out_chan.total_clock),
    .rpt_idle_ticks    (out_chan.idle_ticks)
  );

  assign out_chan.last = status.idx_last;

  // The block never takes new work while a report is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input ready while a report is pending");

  // A run transaction closes the input until the run is reported.
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.operation == mlfq_pkg::OP_RUN))
    |=> !in_chan.ready)
    else $error("input still ready after a run transaction");

  // Returning from I/O needs a non-empty I/O list.
  a_io_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.io_pop |-> (status.io_head_zero && status.io_ne))
    else $error("I/O return without a finished I/O entry");

  // Preemption only happens while the runner still has work left.
  a_preempt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.preempt |-> (status.rb_nz && (status.top_ne || status.mid_ne)))
    else $error("preemption without remaining burst or waiting process");
endmodule

// ----- tb/mlfq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler report checker
// Watches the load, run and register transactions, replays the feedback
// queue scheduling in its own model and compares every report field by field.
// ----------------------------------------------------------------------------
module mlfq_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mlfq_in_if                                    in_mon,
  mlfq_out_if                                   out_mon,
  input  logic                                  cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                    errors,
  output int                                    pending
);
  localparam int NPROC = mlfq_pkg::MAX_PROCS_DEF;
  localparam int NBURST = mlfq_pkg::MAX_BURSTS_DEF;

  typedef struct {
    logic [mlfq_pkg::PCNT_W-1:0] pid;
    logic [mlfq_pkg::CNT_W-1:0]  resp;
    logic [mlfq_pkg::CNT_W-1:0]  waited;
    logic [mlfq_pkg::CNT_W-1:0]  done_at;
    logic [mlfq_pkg::CNT_W-1:0]  total;
    logic [mlfq_pkg::CNT_W-1:0]  idle;
    logic                        last;
  } report_t;

  report_t reports_due[$];

  logic [mlfq_pkg::TIME_W-1:0]  burst_mem [NPROC][NBURST];
  logic [mlfq_pkg::TIME_W-1:0]  io_mem    [NPROC][NBURST];
  int                           list_len  [NPROC];
  int                           pos       [NPROC];
  int                           rem_burst [NPROC];
  int                           rem_io    [NPROC];
  int                           lvl       [NPROC];
  logic [mlfq_pkg::CNT_W-1:0]   waits     [NPROC];
  logic [mlfq_pkg::CNT_W-1:0]   resp      [NPROC];
  logic [mlfq_pkg::CNT_W-1:0]   fin       [NPROC];
  bit                           fresh     [NPROC];
  int                           top_q[$], mid_q[$], low_q[$], io_q[$];
  logic [mlfq_pkg::CNT_W-1:0]   tick_cnt, idle_cnt;
  logic [mlfq_pkg::QUANT_W-1:0] slice1, slice2;
  logic [mlfq_pkg::PCNT_W-1:0]  pcount;

  function automatic logic [mlfq_pkg::CNT_W-1:0] bump(
      input logic [mlfq_pkg::CNT_W-1:0] v);
    return (v == mlfq_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void clear_run();
    for (int i = 0; i < NPROC; i++) begin
      pos[i] = 0;
      rem_burst[i] = 0;
      rem_io[i] = 0;
      lvl[i] = 1;
      waits[i] = '0;
      resp[i] = '0;
      fin[i] = '0;
      fresh[i] = 1'b1;
    end
    top_q.delete();
    mid_q.delete();
    low_q.delete();
    io_q.delete();
    tick_cnt = '0;
    idle_cnt = '0;
  endfunction

  function automatic void requeue(input int id);
    if (lvl[id] <= 1) top_q.push_back(id);
    else if (lvl[id] == 2) mid_q.push_back(id);
    else low_q.push_back(id);
  endfunction

  function automatic void io_step();
    int id;
    foreach (io_q[k])
      if (rem_io[io_q[k]] > 0) rem_io[io_q[k]]--;
    while (io_q.size() > 0 && rem_io[io_q[0]] == 0) begin
      id = io_q.pop_front();
      requeue(id);
    end
  endfunction

  function automatic void tick();
    tick_cnt = bump(tick_cnt);
    foreach (top_q[k]) waits[top_q[k]] = bump(waits[top_q[k]]);
    foreach (mid_q[k]) waits[mid_q[k]] = bump(waits[mid_q[k]]);
    foreach (low_q[k]) waits[low_q[k]] = bump(waits[low_q[k]]);
    io_step();
  endfunction

  function automatic void dispatch(input int id);
    if (rem_burst[id] == 0 && pos[id] < list_len[id]) begin
      rem_burst[id] = burst_mem[id][pos[id]];
      rem_io[id] = io_mem[id][pos[id]];
      pos[id]++;
    end
    if (fresh[id]) begin
      fresh[id] = 1'b0;
      resp[id] = tick_cnt;
    end
  endfunction

  // A burst that is not the last goes to I/O, placed after entries with
  // equal or shorter remaining time.
  function automatic void retire(input int id);
    int k;
    if (pos[id] < list_len[id]) begin
      k = 0;
      while (k < io_q.size() && rem_io[io_q[k]] <= rem_io[id]) k++;
      io_q.insert(k, id);
    end else begin
      fin[id] = tick_cnt;
    end
  endfunction

  function automatic void schedule();
    int id;
    bit pre;
    forever begin
      pre = 1'b0;
      if (top_q.size() != 0) begin
        id = top_q.pop_front();
        dispatch(id);
        for (int t = 0; t < slice1 && rem_burst[id] > 0; t++) begin
          rem_burst[id]--;
          tick();
        end
        if (rem_burst[id] > 0) begin
          lvl[id] = 2;
          mid_q.push_back(id);
        end else begin
          retire(id);
        end
      end else if (mid_q.size() != 0) begin
        id = mid_q.pop_front();
        dispatch(id);
        for (int t = 0; t < slice2 && rem_burst[id] > 0; t++) begin
          rem_burst[id]--;
          tick();
          if (top_q.size() != 0 && rem_burst[id] > 0) begin
            mid_q.push_back(id);
            pre = 1'b1;
            break;
          end
        end
        if (!pre) begin
          if (rem_burst[id] > 0) begin
            lvl[id] = 3;
            low_q.push_back(id);
          end else begin
            retire(id);
          end
        end
      end else if (low_q.size() != 0) begin
        id = low_q.pop_front();
        dispatch(id);
        while (rem_burst[id] > 0) begin
          tick();
          rem_burst[id]--;
          if ((top_q.size() != 0 || mid_q.size() != 0) && rem_burst[id] > 0) begin
            low_q.push_back(id);
            pre = 1'b1;
            break;
          end
        end
        if (!pre) retire(id);
      end else if (io_q.size() != 0) begin
        do begin
          tick_cnt = bump(tick_cnt);
          idle_cnt = bump(idle_cnt);
          io_step();
        end while (top_q.size() == 0 && mid_q.size() == 0 && low_q.size() == 0
                   && io_q.size() != 0);
      end else begin
        break;
      end
    end
  endfunction

  function automatic void run_all();
    int n;
    report_t r;
    clear_run();
    n = (pcount > NPROC) ? NPROC : pcount;
    for (int i = 0; i < n; i++)
      if (list_len[i] > 0) top_q.push_back(i);
    schedule();
    for (int i = 0; i < n; i++) begin
      r.pid = 5'(i + 1);
      r.resp = resp[i];
      r.waited = waits[i];
      r.done_at = fin[i];
      r.total = tick_cnt;
      r.idle = idle_cnt;
      r.last = (i + 1 == n);
      reports_due.push_back(r);
    end
  endfunction

  task automatic check_field(input string name, input logic [mlfq_pkg::CNT_W-1:0] want,
                             input logic [mlfq_pkg::CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    report_t r;
    int p;
    if (!rst_n) begin
      for (int i = 0; i < NPROC; i++) begin
        list_len[i] = 0;
        for (int j = 0; j < NBURST; j++) begin
          burst_mem[i][j] = '0;
          io_mem[i][j] = '0;
        end
      end
      clear_run();
      slice1 = mlfq_pkg::Q1_RESET;
      slice2 = mlfq_pkg::Q2_RESET;
      pcount = mlfq_pkg::PCOUNT_RESET;
      reports_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mlfq_pkg::CFG_QUANTUM1: slice1 = cfg_data;
          mlfq_pkg::CFG_QUANTUM2: slice2 = cfg_data;
          mlfq_pkg::CFG_PCOUNT:   pcount = cfg_data[mlfq_pkg::PCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == mlfq_pkg::OP_APPEND) begin
          p = in_mon.process_index;
          if (list_len[p] < NBURST) begin
            burst_mem[p][list_len[p]] = (in_mon.cpu_burst == '0) ? 12'd1 : in_mon.cpu_burst;
            io_mem[p][list_len[p]] = (in_mon.io_time == '0) ? 12'd1 : in_mon.io_time;
            list_len[p]++;
          end
        end else begin
          run_all();
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (reports_due.size() == 0) begin
          $error("unexpected report for process %0d", out_mon.process_id);
          errors++;
        end else begin
          r = reports_due.pop_front();
          check_field("process_id", r.pid, out_mon.process_id);
          check_field("response_time", r.resp, out_mon.response_time);
          check_field("wait_time", r.waited, out_mon.wait_time);
          check_field("finish_time", r.done_at, out_mon.finish_time);
          check_field("total_clock", r.total, out_mon.total_clock);
          check_field("idle_ticks", r.idle, out_mon.idle_ticks);
          check_field("last", r.last, out_mon.last);
        end
      end
    end
    pending = reports_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback queue scheduler testbench
// Loads burst lists, starts runs under several quantum and process count
// settings with random idling on both channels, and takes its verdict from
// the report checker.
// ----------------------------------------------------------------------------
module testbench;
  localparam longint CYCLE_LIMIT = 60000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mlfq_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int errors, pending;
  longint cycles = 0;
  bit gaps_on = 1'b1;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  mlfq_in_if in_chan ();
  mlfq_out_if out_chan ();

  multilevel_feedback_queue_scheduler u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mlfq_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Report sink: random stalls, plus one long hold-off once armed.
  always @(posedge clk) begin
    logic nr;
    if (!rst_n) begin
      nr = 1'b0;
    end else begin
      if (hold_armed && !hold_done && out_chan.valid) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (out_chan.valid && out_chan.ready)
        stall_left = gaps_on ? $urandom_range(0, 14) : 0;
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
    end
    out_chan.ready <= nr;
  end

  task automatic send(input logic op, input logic [mlfq_pkg::PIDX_W-1:0] idx,
                      input logic [mlfq_pkg::TIME_W-1:0] burst,
                      input logic [mlfq_pkg::TIME_W-1:0] io);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= op;
    in_chan.process_index <= idx;
    in_chan.cpu_burst <= burst;
    in_chan.io_time <= io;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Waits until every report is in, then lets the block settle.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [mlfq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mlfq_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_random();
    logic [mlfq_pkg::TIME_W-1:0] b, io;
    b = ($urandom_range(0, 63) == 0) ? 12'($urandom_range(0, 4095))
                                     : 12'($urandom_range(0, 25));
    io = ($urandom_range(0, 63) == 0) ? 12'($urandom_range(0, 4095))
                                      : 12'($urandom_range(0, 30));
    send(mlfq_pkg::OP_APPEND, 4'($urandom_range(0, 15)), b, io);
  endtask

  initial begin
    int n_items;
    in_chan.valid = 1'b0;
    in_chan.operation = mlfq_pkg::OP_APPEND;
    in_chan.process_index = '0;
    in_chan.cpu_burst = '0;
    in_chan.io_time = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes under the reset register values.
    send(mlfq_pkg::OP_APPEND, 4'd0, 12'd0, 12'd0);
    send(mlfq_pkg::OP_APPEND, 4'd1, 12'd4095, 12'd4095);
    send(mlfq_pkg::OP_APPEND, 4'd1, 12'd2, 12'd0);
    send(mlfq_pkg::OP_APPEND, 4'd2, 12'd30, 12'd5);
    send(mlfq_pkg::OP_APPEND, 4'd2, 12'd3, 12'd9);
    send(mlfq_pkg::OP_APPEND, 4'd3, 12'd20, 12'd2);
    send(mlfq_pkg::OP_APPEND, 4'd4, 12'd1, 12'd3);
    send(mlfq_pkg::OP_APPEND, 4'd15, 12'd2730, 12'd1365);
    send(mlfq_pkg::OP_APPEND, 4'd15, 12'd1365, 12'd2730);
    send(mlfq_pkg::OP_RUN, 4'd0, 12'd0, 12'd0);
    drain();

    // The long hold-off lands on this run while loads keep coming.
    hold_armed = 1'b1;
    send(mlfq_pkg::OP_RUN, 4'd15, 12'd4095, 12'd4095);
    send(mlfq_pkg::OP_APPEND, 4'd6, 12'd40, 12'd1);
    send(mlfq_pkg::OP_APPEND, 4'd6, 12'd9, 12'd4);
    send(mlfq_pkg::OP_APPEND, 4'd7, 12'd15, 12'd3);
    drain();

    cfg_write(mlfq_pkg::CFG_QUANTUM1, 8'd255);
    cfg_write(mlfq_pkg::CFG_QUANTUM2, 8'd255);
    cfg_write(mlfq_pkg::CFG_PCOUNT, 8'd16);
    cfg_we <= 1'b0;
    send(mlfq_pkg::OP_RUN, 4'd0, 12'd0, 12'd0);
    drain();

    // Zero slices demote at dispatch; zero and oversized counts.
    cfg_write(mlfq_pkg::CFG_QUANTUM1, 8'd0);
    cfg_write(mlfq_pkg::CFG_QUANTUM2, 8'd1);
    cfg_write(mlfq_pkg::CFG_PCOUNT, 8'd31);
    cfg_we <= 1'b0;
    send(mlfq_pkg::OP_RUN, 4'd0, 12'd0, 12'd0);
    drain();
    cfg_write(mlfq_pkg::CFG_QUANTUM1, 8'd1);
    cfg_write(mlfq_pkg::CFG_QUANTUM2, 8'd0);
    cfg_write(mlfq_pkg::CFG_PCOUNT, 8'd0);
    cfg_we <= 1'b0;
    send(mlfq_pkg::OP_RUN, 4'd0, 12'd0, 12'd0);
    drain();

    // Random rounds; lists fill up and later appends overflow.
    for (int round = 0; round < 9; round++) begin
      gaps_on = (round % 3 != 1);
      cfg_write(mlfq_pkg::CFG_QUANTUM1, (round == 0) ? 8'd1 : 8'($urandom_range(1, 20)));
      cfg_write(mlfq_pkg::CFG_QUANTUM2, (round == 1) ? 8'd255 : 8'($urandom_range(1, 30)));
      cfg_write(mlfq_pkg::CFG_PCOUNT, (round == 2) ? 8'd1 : 8'($urandom_range(1, 16)));
      cfg_we <= 1'b0;
      n_items = $urandom_range(20, 26);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 19) == 0)
          send(mlfq_pkg::OP_RUN, 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)),
               12'($urandom_range(0, 4095)));
        else
          load_random();
      end
      send(mlfq_pkg::OP_RUN, 4'd0, 12'd0, 12'd0);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
